[design/fte_pkg.sv]
// Shared types and constants of the FAT table entry engine.
package fte_pkg;

   localparam int unsigned SECTORS_PER_BLOCK = 3;
   localparam int unsigned POS_W = 34;
   localparam int unsigned MIN_SECTOR_BYTES = 512;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_NEXT  = 2'd3;

   localparam logic [1:0] KIND_FAT12 = 2'd0;
   localparam logic [1:0] KIND_FAT16 = 2'd1;
   localparam logic [1:0] KIND_FAT32 = 2'd2;
   localparam logic [1:0] KIND_EXFAT = 2'd3;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_MISS  = 3'd1;
   localparam logic [2:0] ST_END   = 3'd2;
   localparam logic [2:0] ST_BAD   = 3'd3;
   localparam logic [2:0] ST_RANGE = 3'd4;

   localparam logic [2:0] REG_FAT_KIND      = 3'd0;
   localparam logic [2:0] REG_END_MASK      = 3'd1;
   localparam logic [2:0] REG_END_LOW       = 3'd2;
   localparam logic [2:0] REG_BAD_MARK      = 3'd3;
   localparam logic [2:0] REG_CLUSTER_TOTAL = 3'd4;
   localparam logic [2:0] REG_SECTOR_BYTES  = 3'd5;

   localparam logic [15:0] NIB_LOW_MASK  = 16'h000f;
   localparam logic [15:0] NIB_HIGH_MASK = 16'hf000;

   localparam logic [20:0] NO_BLOCK = 21'h1fffff;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic done;
   } div_sts_type;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_DIV   = 8'b0000_0010,
      S_CHK   = 8'b0000_0100,
      S_RADDR = 8'b0000_1000,
      S_RDATA = 8'b0001_0000,
      S_CALC  = 8'b0010_0000,
      S_WR    = 8'b0100_0000,
      S_FIN   = 8'b1000_0000
   } state_type;

endpackage

[design/fte_if.sv]
// Request and response channel interfaces of the FAT table entry engine.
interface fte_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] cluster;
   logic [31:0] new_entry;
   logic [13:0] byte_offset;
   logic [7:0]  byte_data;
   logic [19:0] load_block;
   logic        allow_bad;
   logic        contiguous;
   logic [31:0] last_cluster;

   modport source (output valid, operation, cluster, new_entry, byte_offset, byte_data,
                   load_block, allow_bad, contiguous, last_cluster, input ready);
   modport sink (input valid, operation, cluster, new_entry, byte_offset, byte_data,
                 load_block, allow_bad, contiguous, last_cluster, output ready);
endinterface

interface fte_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] entry_out;
   logic [2:0]  status;
   logic [19:0] needed_block;

   modport source (output valid, entry_out, status, needed_block, input ready);
   modport sink (input valid, entry_out, status, needed_block, output ready);
endinterface

[design/fte_div.sv]
// Restoring divider, one quotient bit per cycle, for entry position by block size.
module fte_div #(
   parameter int unsigned DIVISOR_W = 14
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fte_pkg::div_ctl_type       ctl,
   input  logic [fte_pkg::POS_W-1:0]  dividend,
   input  logic [DIVISOR_W-1:0]       divisor,
   output fte_pkg::div_sts_type       sts,
   output logic [fte_pkg::POS_W-1:0]  quotient,
   output logic [DIVISOR_W-1:0]       remainder
);
   import fte_pkg::*;

   localparam int unsigned CNT_W = $clog2(POS_W + 1);

   logic [POS_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[POS_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(POS_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = DIVISOR_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
         end
         quo_in = {quo_ff[POS_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[design/fat_table_entry_engine.sv]
// Top level of the FAT table entry engine: sequencer, block buffer and result register.
//
// Requests arrive on req_bus, results leave on rsp_bus; both are valid/ready
// channels and one request gives exactly one result. The user must write
// configuration through csr_we, csr_index and csr_wdata only while the block
// is idle; the block itself does not enforce this. A load transfer writes one
// buffer byte, if its offset lies inside the buffer, and sets the block tag;
// its result moves through S_FIN into the output register once that is free.
// Read, write and next-cluster requests first divide the entry position by
// the block size in a bit-serial divider. A miss or a contiguous exFAT step
// then goes from S_CHK straight to S_FIN; otherwise the entry is read one byte
// at a time from the single port buffer and, for a write, stored back one byte
// per cycle. One request is worked at a time, and the next transfer can be
// taken in the cycle after the result register is loaded.
// Reset clears the configuration to its defaults and marks no block as held;
// the buffer contents are undefined until loaded. A finished result waits in
// the output register while the receiver stalls, and the next result is only
// written there once the previous one has been taken.
module fat_table_entry_engine #(
   parameter int unsigned MAX_SECTOR_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   fte_req_if.sink     req_bus,
   fte_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import fte_pkg::*;

   localparam int unsigned BUF_BYTES = SECTORS_PER_BLOCK * MAX_SECTOR_BYTES;
   localparam int unsigned ADDR_W    = $clog2(BUF_BYTES);
   localparam int unsigned BS_W      = $clog2(BUF_BYTES + 1);
   localparam int unsigned SB_W      = $clog2(MAX_SECTOR_BYTES + 1);

   // Configuration registers.
   logic [1:0]  fat_kind_ff;
   logic [31:0] end_mask_ff, end_low_ff, bad_mark_ff;
   logic [27:0] cluster_total_ff;
   logic [12:0] sector_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fat_kind_ff      <= KIND_FAT32;
         end_mask_ff      <= 32'd268435455;
         end_low_ff       <= 32'd268435448;
         bad_mark_ff      <= 32'd268435447;
         cluster_total_ff <= '0;
         sector_bytes_ff  <= 13'd512;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FAT_KIND:      fat_kind_ff      <= csr_wdata[1:0];
            REG_END_MASK:      end_mask_ff      <= csr_wdata;
            REG_END_LOW:       end_low_ff       <= csr_wdata;
            REG_BAD_MARK:      bad_mark_ff      <= csr_wdata;
            REG_CLUSTER_TOTAL: cluster_total_ff <= csr_wdata[27:0];
            REG_SECTOR_BYTES:  sector_bytes_ff  <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // Block size: three times the clamped sector size.
   logic [SB_W-1:0] sb_clamped;
   logic [BS_W-1:0] blk_size;

   always_comb begin
      if (sector_bytes_ff < 13'(MIN_SECTOR_BYTES)) begin
         sb_clamped = SB_W'(MIN_SECTOR_BYTES);
      end else if ({1'b0, sector_bytes_ff} > 14'(MAX_SECTOR_BYTES)) begin
         sb_clamped = SB_W'(MAX_SECTOR_BYTES);
      end else begin
         sb_clamped = SB_W'(sector_bytes_ff);
      end
      blk_size = BS_W'({sb_clamped, 1'b0}) + BS_W'(sb_clamped);
   end

   // Request registers.
   logic [1:0]  op_ff;
   logic [31:0] cl_ff, nv_ff, last_ff;
   logic        abad_ff, contig_ff;

   state_type   state_ff, state_in;
   logic [1:0]  k_ff, k_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] wr_word_ff, wr_word_in;
   logic [31:0] res_eo_ff, res_eo_in;
   logic [2:0]  res_st_ff, res_st_in;
   logic [19:0] res_nb_ff, res_nb_in;
   logic [BS_W-1:0] off_ff, off_in;
   logic [20:0] buffered_ff, buffered_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_eo_ff;
   logic [2:0]  rsp_st_ff;
   logic [19:0] rsp_nb_ff;

   logic        req_fire, fin_fire;
   logic        mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [7:0]  mem_wdata;
   logic [7:0]  rd_byte_ff;
   logic [7:0]  buf_mem [BUF_BYTES];

   // Entry position of the requested cluster.
   logic [31:0]      masked_cl;
   logic [POS_W-1:0] pos;
   logic             odd;
   logic [1:0]       last_k;

   assign masked_cl = req_bus.cluster & end_mask_ff;
   assign odd       = cl_ff[0] & end_mask_ff[0];
   assign last_k    = (fat_kind_ff == KIND_FAT12 || fat_kind_ff == KIND_FAT16) ? 2'd1 : 2'd3;

   always_comb begin
      case (fat_kind_ff)
         KIND_FAT12: pos = POS_W'(({2'b00, masked_cl} + {1'b0, masked_cl, 1'b0}) >> 1);
         KIND_FAT16: pos = POS_W'({masked_cl, 1'b0});
         default:    pos = {masked_cl, 2'b00};
      endcase
   end

   div_ctl_type      div_ctl;
   div_sts_type      div_sts;
   logic [POS_W-1:0] quotient;
   logic [BS_W-1:0]  remainder;

   fte_div #(.DIVISOR_W(BS_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (pos),
      .divisor   (blk_size),
      .sts       (div_sts),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // Buffer index of byte k of the entry, wrapped at the block size.
   logic [BS_W:0] idx_sum, idx_wrap;
   assign idx_sum  = {1'b0, off_ff} + (BS_W + 1)'(k_ff);
   assign idx_wrap = (idx_sum >= {1'b0, blk_size}) ? idx_sum - {1'b0, blk_size} : idx_sum;

   // Entry value as stored, and the FAT12 merged word for a write.
   logic [31:0] raw_entry, entry_val, new_val;
   logic [15:0] merged12;
   logic        block_hit;
   logic [32:0] range_top;

   always_comb begin
      if (fat_kind_ff == KIND_FAT12) begin
         raw_entry = odd ? {20'd0, word_ff[15:4]} : {16'd0, word_ff[15:0]};
      end else if (fat_kind_ff == KIND_FAT16) begin
         raw_entry = {16'd0, word_ff[15:0]};
      end else begin
         raw_entry = word_ff;
      end
      entry_val = raw_entry & end_mask_ff;
      new_val   = nv_ff & end_mask_ff;
      merged12  = odd ? ({new_val[11:0], 4'd0} | (word_ff[15:0] & NIB_LOW_MASK))
                      : ((word_ff[15:0] & NIB_HIGH_MASK) | new_val[15:0]);
      range_top = {5'd0, cluster_total_ff} + 33'd2;
   end

   // The full block number is compared with the 21-bit tag.
   assign block_hit = (quotient[POS_W-1:21] == '0) && (quotient[20:0] == buffered_ff);

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign fin_fire      = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      word_in       = word_ff;
      wr_word_in    = wr_word_ff;
      res_eo_in     = res_eo_ff;
      res_st_in     = res_st_ff;
      res_nb_in     = res_nb_ff;
      off_in        = off_ff;
      buffered_in   = buffered_ff;
      div_ctl.start = 1'b0;
      mem_we        = 1'b0;
      mem_addr      = idx_wrap[ADDR_W-1:0];
      mem_wdata     = wr_word_ff[k_ff*8 +: 8];
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_bus.operation == OP_LOAD) begin
                  mem_addr    = req_bus.byte_offset[ADDR_W-1:0];
                  mem_wdata   = req_bus.byte_data;
                  mem_we      = {1'b0, req_bus.byte_offset} < 15'(BUF_BYTES);
                  buffered_in = {1'b0, req_bus.load_block};
                  res_eo_in   = '0;
                  res_st_in   = ST_OK;
                  res_nb_in   = req_bus.load_block;
                  state_in    = S_FIN;
               end else begin
                  div_ctl.start = 1'b1;
                  state_in      = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_sts.done) begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            res_nb_in = quotient[19:0];
            off_in    = remainder;
            k_in      = 2'd0;
            word_in   = '0;
            res_eo_in = '0;
            res_st_in = ST_OK;
            if (op_ff == OP_NEXT && fat_kind_ff == KIND_EXFAT && contig_ff) begin
               if (cl_ff < last_ff) begin
                  res_eo_in = cl_ff + 32'd1;
               end else begin
                  res_eo_in = end_mask_ff;
                  res_st_in = ST_END;
               end
               state_in = S_FIN;
            end else if (!block_hit) begin
               res_st_in = ST_MISS;
               state_in  = S_FIN;
            end else begin
               state_in = S_RADDR;
            end
         end
         S_RADDR: begin
            state_in = S_RDATA;
         end
         S_RDATA: begin
            word_in[k_ff*8 +: 8] = rd_byte_ff;
            if (k_ff == last_k) begin
               state_in = S_CALC;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_RADDR;
            end
         end
         S_CALC: begin
            k_in      = 2'd0;
            res_st_in = ST_OK;
            state_in  = S_FIN;
            case (op_ff)
               OP_READ: res_eo_in = entry_val;
               OP_WRITE: begin
                  res_eo_in  = new_val;
                  wr_word_in = (fat_kind_ff == KIND_FAT12) ? {16'd0, merged12} : new_val;
                  state_in   = S_WR;
               end
               default: begin
                  if (entry_val >= end_low_ff && entry_val <= end_mask_ff) begin
                     res_eo_in = end_mask_ff;
                     res_st_in = ST_END;
                  end else if (entry_val == bad_mark_ff && abad_ff) begin
                     res_eo_in = entry_val;
                     res_st_in = ST_BAD;
                  end else if ({1'b0, entry_val} >= range_top) begin
                     res_eo_in = end_mask_ff;
                     res_st_in = ST_RANGE;
                  end else begin
                     res_eo_in = entry_val;
                  end
               end
            endcase
         end
         S_WR: begin
            mem_we = 1'b1;
            if (k_ff == last_k) begin
               state_in = S_FIN;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_FIN: begin
            if (fin_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Block buffer: one port, registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         buf_mem[mem_addr] <= mem_wdata;
      end
      rd_byte_ff <= buf_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= req_bus.operation;
         cl_ff     <= req_bus.cluster;
         nv_ff     <= req_bus.new_entry;
         last_ff   <= req_bus.last_cluster;
         abad_ff   <= req_bus.allow_bad;
         contig_ff <= req_bus.contiguous;
      end
      k_ff       <= k_in;
      word_ff    <= word_in;
      wr_word_ff <= wr_word_in;
      res_eo_ff  <= res_eo_in;
      res_st_ff  <= res_st_in;
      res_nb_ff  <= res_nb_in;
      off_ff     <= off_in;
      if (fin_fire) begin
         rsp_eo_ff <= res_eo_ff;
         rsp_st_ff <= res_st_ff;
         rsp_nb_ff <= res_nb_ff;
      end
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_bus.ready) || fin_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         buffered_ff  <= NO_BLOCK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         buffered_ff  <= buffered_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.entry_out    = rsp_eo_ff;
   assign rsp_bus.status       = rsp_st_ff;
   assign rsp_bus.needed_block = rsp_nb_ff;

endmodule

[bench/fat_table_entry_engine_tb.sv]
// Self-checking testbench of the FAT table entry engine with its entry predictor.
module fat_table_entry_engine_tb;
   import fte_pkg::*;

   localparam int unsigned MAX_SB = 512;
   localparam int unsigned BUF_BYTES = SECTORS_PER_BLOCK * MAX_SB;
   localparam int unsigned SETTLE_CYCLES = 80;
   localparam int unsigned HOLD_CYCLES = 400;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] cluster;
      logic [31:0] new_entry;
      logic [13:0] byte_offset;
      logic [7:0]  byte_data;
      logic [19:0] load_block;
      logic        allow_bad;
      logic        contiguous;
      logic [31:0] last_cluster;
   } fat_req_t;

   typedef struct packed {
      logic [31:0] entry;
      logic [2:0]  status;
      logic [19:0] block;
   } fat_rsp_t;

   class fat_scoreboard;
      logic [1:0]  kind;
      logic [31:0] emask;
      logic [31:0] elow;
      logic [31:0] bmark;
      logic [27:0] ctotal;
      logic [12:0] sbytes;
      logic [7:0]  fat_buf[BUF_BYTES];
      bit          loaded[BUF_BYTES];
      logic [20:0] held_block;
      fat_rsp_t    awaited_q[$];
      int          errors;

      function new();
         kind = KIND_FAT32;
         emask = 32'h0fff_ffff;
         elow = 32'h0fff_fff8;
         bmark = 32'h0fff_fff7;
         ctotal = '0;
         sbytes = 13'd512;
         held_block = NO_BLOCK;
         errors = 0;
         foreach (fat_buf[i]) begin
            fat_buf[i] = '0;
            loaded[i] = 1'b0;
         end
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_FAT_KIND:      kind = val[1:0];
            REG_END_MASK:      emask = val;
            REG_END_LOW:       elow = val;
            REG_BAD_MARK:      bmark = val;
            REG_CLUSTER_TOTAL: ctotal = val[27:0];
            REG_SECTOR_BYTES:  sbytes = val[12:0];
            default: ;
         endcase
      endfunction

      function longint unsigned block_bytes();
         longint unsigned sb;
         sb = sbytes;
         if (sb < MIN_SECTOR_BYTES) sb = MIN_SECTOR_BYTES;
         if (sb > MAX_SB) sb = MAX_SB;
         return sb * SECTORS_PER_BLOCK;
      endfunction

      function longint unsigned entry_pos(logic [31:0] cl);
         longint unsigned m;
         m = cl & emask;
         if (kind == KIND_FAT12) return (m * 3) / 2;
         if (kind == KIND_FAT16) return m * 2;
         return m * 4;
      endfunction

      function longint unsigned block_of(logic [31:0] cl);
         return entry_pos(cl) / block_bytes();
      endfunction

      // Buffer index of byte k of the entry; positions wrap within the block.
      function int unsigned byte_index(logic [31:0] cl, int unsigned k);
         return int'((entry_pos(cl) % block_bytes() + k) % block_bytes());
      endfunction

      function logic [31:0] peek(logic [31:0] cl, int unsigned k);
         int unsigned i;
         i = byte_index(cl, k);
         return (i < BUF_BYTES) ? {24'b0, fat_buf[i]} : 32'b0;
      endfunction

      function void poke(logic [31:0] cl, int unsigned k, logic [31:0] v);
         int unsigned i;
         i = byte_index(cl, k);
         if (i < BUF_BYTES) begin
            fat_buf[i] = v[7:0];
            loaded[i] = 1'b1;
         end
      endfunction

      function logic [31:0] fetch_entry(logic [31:0] cl);
         logic [31:0] w;
         if (kind == KIND_FAT12 || kind == KIND_FAT16) begin
            w = peek(cl, 0) | (peek(cl, 1) << 8);
            if (kind == KIND_FAT12 && cl[0] && emask[0]) w = w >> 4;
         end else begin
            w = peek(cl, 0) | (peek(cl, 1) << 8) | (peek(cl, 2) << 16) | (peek(cl, 3) << 24);
         end
         return w & emask;
      endfunction

      function logic [31:0] store_entry(logic [31:0] cl, logic [31:0] val);
         logic [31:0] v, prev, nw;
         v = val & emask;
         if (kind == KIND_FAT12) begin
            prev = peek(cl, 0) | (peek(cl, 1) << 8);
            if (cl[0] && emask[0]) nw = (prev & NIB_LOW_MASK) | (v << 4);
            else nw = (prev & NIB_HIGH_MASK) | v;
            poke(cl, 0, nw);
            poke(cl, 1, nw >> 8);
         end else if (kind == KIND_FAT16) begin
            poke(cl, 0, v);
            poke(cl, 1, v >> 8);
         end else begin
            for (int k = 0; k < 4; k++) poke(cl, k, v >> (8 * k));
         end
         return v;
      endfunction

      function void note(fat_req_t it);
         fat_rsp_t r;
         longint unsigned blk;
         logic [31:0] v;
         r = '0;
         if (it.operation == OP_LOAD) begin
            if (it.byte_offset < BUF_BYTES) begin
               fat_buf[it.byte_offset] = it.byte_data;
               loaded[it.byte_offset] = 1'b1;
            end
            held_block = {1'b0, it.load_block};
            r.block = it.load_block;
         end else begin
            blk = block_of(it.cluster);
            r.block = blk[19:0];
            if (it.operation == OP_NEXT && kind == KIND_EXFAT && it.contiguous) begin
               if (it.cluster < it.last_cluster) r.entry = it.cluster + 1;
               else begin
                  r.entry = emask;
                  r.status = ST_END;
               end
            end else if (blk != held_block) begin
               r.status = ST_MISS;
            end else if (it.operation == OP_READ) begin
               r.entry = fetch_entry(it.cluster);
            end else if (it.operation == OP_WRITE) begin
               r.entry = store_entry(it.cluster, it.new_entry);
            end else begin
               v = fetch_entry(it.cluster);
               if (v >= elow && v <= emask) begin
                  r.entry = emask;
                  r.status = ST_END;
               end else if (v == bmark && it.allow_bad) begin
                  r.entry = v;
                  r.status = ST_BAD;
               end else if (longint'(v) >= longint'(ctotal) + 2) begin
                  r.entry = emask;
                  r.status = ST_RANGE;
               end else begin
                  r.entry = v;
               end
            end
         end
         awaited_q.push_back(r);
      endfunction

      function void check(fat_rsp_t got);
         fat_rsp_t exp;
         if (awaited_q.size() == 0) begin
            $display("%0t: result with nothing expected: entry %h status %0d block %h",
                     $time, got.entry, got.status, got.block);
            errors++;
            return;
         end
         exp = awaited_q.pop_front();
         if (got.entry !== exp.entry) begin
            $display("%0t: entry_out expected %h actual %h", $time, exp.entry, got.entry);
            errors++;
         end
         if (got.status !== exp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
            errors++;
         end
         if (got.block !== exp.block) begin
            $display("%0t: needed_block expected %h actual %h", $time, exp.block, got.block);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = REG_FAT_KIND;
   logic [31:0] csr_wdata = '0;

   fte_req_if req_bus();
   fte_rsp_if rsp_bus();

   fat_table_entry_engine DUT (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   fat_scoreboard fat_sb = new();
   bit quiet = 1'b0;
   bit hold_request = 1'b0;

   always #5 clock = ~clock;

   initial begin
      #8_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int unsigned gap_len();
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Results are taken whenever valid and ready meet at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         fat_sb.check('{rsp_bus.entry_out, rsp_bus.status, rsp_bus.needed_block});
   end

   initial begin
      int unsigned g;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_bus.ready = 1'b0;
            hold_request = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            g = gap_len();
            if (g > 0) begin
               rsp_bus.ready = 1'b0;
               repeat (g) @(negedge clock);
            end
         end
         rsp_bus.ready = 1'b1;
         @(negedge clock);
      end
   end

   task automatic push(fat_req_t it);
      int unsigned g;
      @(negedge clock);
      req_bus.operation = it.operation;
      req_bus.cluster = it.cluster;
      req_bus.new_entry = it.new_entry;
      req_bus.byte_offset = it.byte_offset;
      req_bus.byte_data = it.byte_data;
      req_bus.load_block = it.load_block;
      req_bus.allow_bad = it.allow_bad;
      req_bus.contiguous = it.contiguous;
      req_bus.last_cluster = it.last_cluster;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      fat_sb.note(it);
      g = gap_len();
      if (g > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   task automatic load_byte(logic [13:0] off, logic [7:0] data, logic [19:0] blk);
      fat_req_t it;
      it = '0;
      it.operation = OP_LOAD;
      it.byte_offset = off;
      it.byte_data = data;
      it.load_block = blk;
      push(it);
   endtask

   // Any not yet loaded buffer byte whose value a hit would use is loaded first, under the held tag.
   task automatic prime_bytes(fat_req_t it);
      int unsigned n, i;
      bit reads;
      if (it.operation == OP_LOAD) return;
      if (fat_sb.block_of(it.cluster) != fat_sb.held_block) return;
      if (it.operation == OP_NEXT && fat_sb.kind == KIND_EXFAT && it.contiguous) return;
      reads = (it.operation != OP_WRITE) || (fat_sb.kind == KIND_FAT12);
      if (!reads) return;
      n = (fat_sb.kind == KIND_FAT12 || fat_sb.kind == KIND_FAT16) ? 2 : 4;
      for (int k = 0; k < n; k++) begin
         i = fat_sb.byte_index(it.cluster, k);
         if (!fat_sb.loaded[i])
            load_byte(14'(i), 8'($urandom_range(0, 255)), fat_sb.held_block[19:0]);
      end
   endtask

   task automatic issue(logic [1:0] op, logic [31:0] cl, logic [31:0] nv,
                        logic abad, logic contig, logic [31:0] last);
      fat_req_t it;
      it = '0;
      it.operation = op;
      it.cluster = cl;
      it.new_entry = nv;
      it.allow_bad = abad;
      it.contiguous = contig;
      it.last_cluster = last;
      it.byte_offset = 14'($urandom_range(0, 16383));
      it.byte_data = 8'($urandom_range(0, 255));
      it.load_block = 20'($urandom);
      prime_bytes(it);
      push(it);
   endtask

   task automatic configure(logic [1:0] kind, logic [31:0] emask, logic [31:0] elow,
                            logic [31:0] bmark, logic [31:0] total, logic [31:0] sbytes);
      logic [31:0] vals[6];
      vals = '{{30'b0, kind}, emask, elow, bmark, total, sbytes};
      for (int i = 0; i < 6; i++) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         csr_we = 1'b1;
         csr_index = 3'(i);
         csr_wdata = vals[i];
         @(posedge clock);
         fat_sb.write_reg(3'(i), vals[i]);
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Waits until every result is in, then lets any unfinished work run out.
   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (fat_sb.awaited_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 9);
      case (r)
         0, 1: return fat_sb.elow + $urandom_range(0, 7);
         2: return fat_sb.emask;
         3, 4: return fat_sb.bmark;
         5: return 32'(fat_sb.ctotal) + 2 + $urandom_range(0, 3);
         6: return $urandom;
         default: return $urandom_range(0, 40);
      endcase
   endfunction

   task automatic random_item();
      fat_req_t it;
      int unsigned r, per_block;
      longint unsigned m, base;
      logic [19:0] tag;
      it = '0;
      r = $urandom_range(0, 99);
      tag = (fat_sb.held_block == NO_BLOCK) ? 20'd0 : fat_sb.held_block[19:0];
      it.byte_offset = 14'($urandom_range(0, 16383));
      it.byte_data = 8'($urandom_range(0, 255));
      it.load_block = 20'($urandom);
      it.new_entry = pick_value();
      it.allow_bad = 1'($urandom_range(0, 1));
      it.contiguous = 1'($urandom_range(0, 1));
      if (r < 15) begin
         it.operation = OP_LOAD;
         if ($urandom_range(0, 19) != 0) it.byte_offset = 14'($urandom_range(0, BUF_BYTES - 1));
         if ($urandom_range(0, 9) != 0) it.load_block = tag;
         else if ($urandom_range(0, 1)) it.load_block = 20'($urandom_range(0, 3));
         push(it);
         return;
      end
      it.operation = (r < 40) ? OP_READ : (r < 70) ? OP_WRITE : OP_NEXT;
      per_block = (fat_sb.kind == KIND_FAT12) ? 1024 : (fat_sb.kind == KIND_FAT16) ? 768 : 384;
      if ($urandom_range(0, 4) != 0) begin
         base = longint'(tag) * per_block;
         m = base + (($urandom_range(0, 3) != 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, per_block - 1));
         it.cluster = (32'(m) & fat_sb.emask) | ($urandom & ~fat_sb.emask);
      end else begin
         it.cluster = $urandom;
      end
      // A held tag of all ones must never be matched by a wide block number.
      if (fat_sb.held_block == NO_BLOCK && fat_sb.block_of(it.cluster) == NO_BLOCK)
         it.cluster = 32'($urandom_range(0, 255));
      it.last_cluster = $urandom_range(0, 1) ? it.cluster + $urandom_range(0, 2) - 1 : $urandom;
      prime_bytes(it);
      push(it);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.operation = OP_LOAD;
      req_bus.cluster = '0;
      req_bus.new_entry = '0;
      req_bus.byte_offset = '0;
      req_bus.byte_data = '0;
      req_bus.load_block = '0;
      req_bus.allow_bad = 1'b0;
      req_bus.contiguous = 1'b0;
      req_bus.last_cluster = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      // Directed: FAT32 defaults, miss before any load, load extremes, chain outcomes.
      issue(OP_READ, 32'd2, 32'd0, 1'b0, 1'b0, 32'd0);
      load_byte(14'd12287, 8'hff, 20'hfffff);
      issue(OP_NEXT, 32'hffff_ffff, 32'd0, 1'b1, 1'b1, 32'hffff_ffff);
      load_byte(14'd1535, 8'h00, 20'd0);
      load_byte(14'd1536, 8'h5a, 20'd0);
      load_byte(14'd0, 8'hff, 20'd0);
      drain();
      configure(KIND_FAT32, 32'h0fff_ffff, 32'h0fff_fff8, 32'h0fff_fff7, 32'd1000, 32'd512);
      issue(OP_WRITE, 32'd3, 32'hffff_ffff, 1'b0, 1'b0, 32'd0);
      issue(OP_NEXT, 32'd3, 32'd0, 1'b0, 1'b0, 32'd0);
      issue(OP_WRITE, 32'd4, 32'h0fff_fff7, 1'b0, 1'b0, 32'd0);
      issue(OP_NEXT, 32'd4, 32'd0, 1'b1, 1'b0, 32'd0);
      issue(OP_NEXT, 32'd4, 32'd0, 1'b0, 1'b0, 32'd0);
      issue(OP_WRITE, 32'd5, 32'd1002, 1'b0, 1'b0, 32'd0);
      issue(OP_NEXT, 32'd5, 32'd0, 1'b0, 1'b0, 32'd0);
      issue(OP_WRITE, 32'd383, 32'd7, 1'b0, 1'b0, 32'd0);
      issue(OP_NEXT, 32'd383, 32'd0, 1'b0, 1'b0, 32'd0);
      issue(OP_READ, 32'hf000_0000, 32'd0, 1'b0, 1'b0, 32'd0);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: configure(KIND_FAT12, 32'hfff, 32'hff8, 32'hff7, 32'd4000, 32'd512);
            1: configure(KIND_FAT16, 32'hffff, 32'hfff8, 32'hfff7, 32'd60000, 32'd4096);
            2: configure(KIND_EXFAT, 32'hffff_ffff, 32'hffff_fff8, 32'hffff_fff7,
                         32'h0fff_ffff, 32'd0);
            3: configure(KIND_FAT32, 32'd0, 32'd0, 32'd0, 32'd0, 32'd8191);
            4: configure(KIND_FAT12, 32'hffff_ffff, 32'h10, 32'h5, 32'd20, 32'd1024);
            5: configure(KIND_FAT16, 32'hff, 32'hf0, 32'h7, 32'd100, 32'd512);
            6: configure(KIND_EXFAT, 32'h0fff_ffff, 32'hffff_fff8, 32'h0fff_fff7,
                         32'h0fff_ffff, 32'd512);
            default: configure(KIND_FAT32, 32'h0fff_ffff, 32'h0fff_fff8, 32'h0fff_fff7,
                               32'd50, 32'd512);
         endcase
         quiet = (phase == 2 || phase == 5);
         if (phase == 0) begin
            // FAT12 nibble merge on an even and an odd neighbour.
            issue(OP_WRITE, 32'd10, 32'habc, 1'b0, 1'b0, 32'd0);
            issue(OP_WRITE, 32'd11, 32'h123, 1'b0, 1'b0, 32'd0);
            issue(OP_READ, 32'd10, 32'd0, 1'b0, 1'b0, 32'd0);
            issue(OP_READ, 32'd11, 32'd0, 1'b0, 1'b0, 32'd0);
         end
         if (phase == 2) begin
            issue(OP_NEXT, 32'd7, 32'd0, 1'b0, 1'b1, 32'd9);
            issue(OP_NEXT, 32'd9, 32'd0, 1'b0, 1'b1, 32'd9);
         end
         for (int n = 0; n < 115; n++) begin
            if (phase == 3 && n == 20) hold_request = 1'b1;
            random_item();
         end
         drain();
      end

      if (fat_sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
